// ===== sv/swsr_pkg.sv =====
// Package: types and constants for the sliding-window sender with RTO estimator.
package swsr_pkg;

    localparam int WindowDepth = 4;
    localparam int SlotBits = $clog2(WindowDepth);
    localparam int CountBits = $clog2(WindowDepth + 1);
    localparam int MaxSegmentBytes = 1024;

    localparam logic [1:0] REQ_SEND = 2'd0;
    localparam logic [1:0] REQ_ACK  = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    localparam logic [2:0] ACT_SENT    = 3'd0;
    localparam logic [2:0] ACT_REFUSED = 3'd1;
    localparam logic [2:0] ACT_ACKED   = 3'd2;
    localparam logic [2:0] ACT_RETX    = 3'd3;
    localparam logic [2:0] ACT_IDLE    = 3'd4;

    localparam logic [2:0] CFG_RTO_MIN   = 3'd0;
    localparam logic [2:0] CFG_RTO_MAX   = 3'd1;
    localparam logic [2:0] CFG_INIT_RTO  = 3'd2;
    localparam logic [2:0] CFG_INIT_SRTT = 3'd3;
    localparam logic [2:0] CFG_INIT_WIN  = 3'd4;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [10:0] seg_length;
        logic [31:0] ack_number;
        logic [15:0] advertised_window;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] seg_seq;
        logic [10:0] out_length;
        logic [12:0] bytes_outstanding;
        logic [12:0] current_rto_ms;
        logic [2:0]  segments_released;
        logic        window_empty;
    } out_item_t;

    typedef enum logic [1:0] {
        EV_SEND,
        EV_ACK,
        EV_TICK,
        EV_NONE
    } ev_kind_t;

    typedef struct packed {
        ev_kind_t    kind;
        logic        len_ok;
        logic [10:0] seg_length;
        logic [31:0] ack_number;
        logic [15:0] advertised_window;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRTT,
        ST_DEV,
        ST_RTO,
        ST_POP,
        ST_OUT
    } be_state_t;

endpackage

// ===== sv/swsr_front.sv =====
// Front end: input transfer, event classification and a two-entry command queue.
module swsr_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  swsr_pkg::in_item_t in_data,
    output logic              cmd_valid,
    input  logic              cmd_take,
    output swsr_pkg::cmd_t    cmd
);
    import swsr_pkg::*;

    cmd_t       q_reg [2];
    logic       rd_reg;
    logic       wr_reg;
    logic [1:0] cnt_reg;
    cmd_t       c;
    logic       push;

    always_comb
    begin
        case (in_data.req_type)
            REQ_SEND: c.kind = EV_SEND;
            REQ_ACK:  c.kind = EV_ACK;
            REQ_TICK: c.kind = EV_TICK;
            default:  c.kind = EV_NONE;
        endcase
        c.len_ok = (in_data.seg_length != 11'd0) &&
                   (in_data.seg_length <= 11'(MaxSegmentBytes));
        c.seg_length = in_data.seg_length;
        c.ack_number = in_data.ack_number;
        c.advertised_window = in_data.advertised_window;
    end

    assign in_stall  = (cnt_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (cmd_take)
            begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(cmd_take);
        end
    end
endmodule

// ===== sv/swsr_back.sv =====
// Back end: window ring, byte counters, RTO estimator and result register.
module swsr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_take,
    input  swsr_pkg::cmd_t     cmd,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               out_valid,
    input  logic               out_stall,
    output swsr_pkg::out_item_t out_data
);
    import swsr_pkg::*;

    be_state_t state_reg, state_next;
    cmd_t      cur_reg, cur_next;

    logic [12:0] rto_min_reg, rto_min_next;
    logic [12:0] rto_max_reg, rto_max_next;
    logic [31:0] now_reg, now_next;
    logic [SlotBits-1:0] head_reg, head_next;
    logic [CountBits-1:0] count_reg, count_next;
    logic [31:0] nseq_reg, nseq_next;
    logic [31:0] lsent_reg, lsent_next;
    logic [31:0] lacked_reg, lacked_next;
    logic [15:0] pwin_reg, pwin_next;
    logic [15:0] srtt_reg, srtt_next;
    logic [15:0] dev_reg, dev_next;
    logic [15:0] rto_reg, rto_next;
    logic [15:0] samp_reg, samp_next;
    logic [2:0]  rel_reg, rel_next;
    logic [WindowDepth-1:0] resent_reg, resent_next;
    out_item_t   res_reg, res_next;
    logic        ov_reg, ov_next;

    logic [31:0] slot_seq [WindowDepth];
    logic [10:0] slot_len [WindowDepth];
    logic [31:0] slot_time [WindowDepth];

    logic        wr_en;
    logic [SlotBits-1:0] wr_idx;
    logic [31:0] wr_seq;
    logic [10:0] wr_len;
    logic        tm_en;
    logic [31:0] tm_val;

    logic [31:0] inflight, elapsed, hend, tick_el;
    logic [34:0] el8, tick8;
    logic [17:0] s3;
    logic [15:0] diff;
    logic [17:0] d3;
    logic [18:0] rto_raw;
    logic [15:0] lo8, hi8;
    logic [16:0] dbl;
    logic [SlotBits-1:0] tail;

    assign cfg_ready = (state_reg == ST_IDLE) && !cmd_valid && !ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = res_reg;
    assign lo8 = {rto_min_reg, 3'b000};
    assign hi8 = {rto_max_reg, 3'b000};
    assign inflight = lsent_reg - lacked_reg;
    assign elapsed = now_reg - slot_time[head_reg];
    assign el8 = {elapsed, 3'b000};
    assign hend = slot_seq[head_reg] + 32'(slot_len[head_reg]);
    assign tick_el = now_reg + 32'd1 - slot_time[head_reg];
    assign tick8 = {tick_el, 3'b000};
    assign s3 = 18'(srtt_reg) * 18'd3 + 18'(samp_reg);
    assign diff = (samp_reg >= srtt_reg) ? samp_reg - srtt_reg : srtt_reg - samp_reg;
    assign d3 = 18'(dev_reg) + 18'(diff) * 18'd3;
    assign rto_raw = 19'(srtt_reg) + 19'({dev_reg, 2'b00});
    assign dbl = {rto_reg, 1'b0};
    assign tail = head_reg + count_reg[SlotBits-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_seq[wr_idx] <= wr_seq;
            slot_len[wr_idx] <= wr_len;
        end
        if (tm_en)
        begin
            slot_time[wr_idx] <= tm_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rto_min_reg <= 13'd100;
            rto_max_reg <= 13'd5000;
            now_reg     <= '0;
            head_reg    <= '0;
            count_reg   <= '0;
            nseq_reg    <= 32'd1;
            lsent_reg   <= '0;
            lacked_reg  <= '0;
            pwin_reg    <= 16'd1024;
            srtt_reg    <= 16'd4000;
            dev_reg     <= '0;
            rto_reg     <= 16'd8000;
            resent_reg  <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rto_min_reg <= rto_min_next;
            rto_max_reg <= rto_max_next;
            now_reg     <= now_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            nseq_reg    <= nseq_next;
            lsent_reg   <= lsent_next;
            lacked_reg  <= lacked_next;
            pwin_reg    <= pwin_next;
            srtt_reg    <= srtt_next;
            dev_reg     <= dev_next;
            rto_reg     <= rto_next;
            resent_reg  <= resent_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        samp_reg <= samp_next;
        rel_reg  <= rel_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cur_next = cur_reg;
        rto_min_next = rto_min_reg;
        rto_max_next = rto_max_reg;
        now_next = now_reg;
        head_next = head_reg;
        count_next = count_reg;
        nseq_next = nseq_reg;
        lsent_next = lsent_reg;
        lacked_next = lacked_reg;
        pwin_next = pwin_reg;
        srtt_next = srtt_reg;
        dev_next = dev_reg;
        rto_next = rto_reg;
        samp_next = samp_reg;
        rel_next = rel_reg;
        resent_next = resent_reg;
        res_next = res_reg;
        ov_next = ov_reg;
        cmd_take = 1'b0;
        wr_en = 1'b0;
        wr_idx = head_reg;
        wr_seq = nseq_reg;
        wr_len = cur_reg.seg_length;
        tm_en = 1'b0;
        tm_val = now_reg;

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RTO_MIN:   rto_min_next = cfg_data[12:0];
                CFG_RTO_MAX:   rto_max_next = cfg_data[12:0];
                CFG_INIT_RTO:  rto_next = {cfg_data[12:0], 3'b000};
                CFG_INIT_SRTT: srtt_next = {cfg_data[12:0], 3'b000};
                CFG_INIT_WIN:  pwin_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && !ov_reg)
                begin
                    cmd_take = 1'b1;
                    cur_next = cmd;
                    rel_next = '0;
                    res_next.action = ACT_IDLE;
                    res_next.seg_seq = '0;
                    res_next.out_length = '0;
                    state_next = ST_OUT;
                    case (cmd.kind)
                        EV_SEND:
                        begin
                            if (!cmd.len_ok || count_reg >= CountBits'(WindowDepth) ||
                                inflight >= 32'(pwin_reg))
                            begin
                                res_next.action = ACT_REFUSED;
                            end
                            else
                            begin
                                wr_en = 1'b1;
                                wr_idx = tail;
                                wr_len = cmd.seg_length;
                                tm_en = 1'b1;
                                resent_next[tail] = 1'b0;
                                lsent_next = nseq_reg + 32'(cmd.seg_length) - 32'd1;
                                nseq_next = nseq_reg + 32'(cmd.seg_length);
                                count_next = count_reg + CountBits'(1);
                                res_next.action = ACT_SENT;
                                res_next.seg_seq = nseq_reg;
                                res_next.out_length = cmd.seg_length;
                            end
                        end
                        EV_ACK:
                        begin
                            pwin_next = cmd.advertised_window;
                            res_next.action = ACT_ACKED;
                            samp_next = (el8[34:16] != '0) ? 16'hFFFF : el8[15:0];
                            if (count_reg != '0 && !resent_reg[head_reg])
                            begin
                                state_next = ST_SRTT;
                            end
                            else
                            begin
                                state_next = ST_POP;
                            end
                        end
                        EV_TICK:
                        begin
                            now_next = now_reg + 32'd1;
                            if (count_reg != '0 && 35'(tick8) >= 35'(rto_reg))
                            begin
                                rto_next = (dbl > 17'(hi8)) ? hi8 : dbl[15:0];
                                tm_en = 1'b1;
                                tm_val = now_reg + 32'd1;
                                resent_next[head_reg] = 1'b1;
                                res_next.action = ACT_RETX;
                                res_next.seg_seq = slot_seq[head_reg];
                                res_next.out_length = slot_len[head_reg];
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SRTT:
            begin
                srtt_next = s3[17:2];
                state_next = ST_DEV;
            end
            ST_DEV:
            begin
                dev_next = d3[17:2];
                state_next = ST_RTO;
            end
            ST_RTO:
            begin
                if (rto_raw > 19'(hi8) || lo8 > hi8)
                begin
                    rto_next = (rto_raw < 19'(lo8) && lo8 <= hi8) ? lo8 : hi8;
                end
                else if (rto_raw < 19'(lo8))
                begin
                    rto_next = lo8;
                end
                else
                begin
                    rto_next = rto_raw[15:0];
                end
                state_next = ST_POP;
            end
            ST_POP:
            begin
                if (count_reg != '0 && hend <= cur_reg.ack_number)
                begin
                    lacked_next = hend - 32'd1;
                    resent_next[head_reg] = 1'b0;
                    head_next = head_reg + SlotBits'(1);
                    count_next = count_reg - CountBits'(1);
                    rel_next = rel_reg + 3'd1;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!ov_reg)
                begin
                    res_next.bytes_outstanding = inflight[12:0];
                    res_next.current_rto_ms = rto_reg[15:3];
                    res_next.segments_released = rel_reg;
                    res_next.window_empty = (count_reg == '0);
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

// ===== sv/sliding_window_sender_rto_core.sv =====
// Top level: sliding-window sender with adaptive retransmission timeout.
// One result per event. A send, refused send, tick or undefined event is classified and
// updated, then goes to the result register. An ACK that takes an RTT sample runs three
// estimator steps (SRTT, deviation, RTO), then the ring pop loop, which releases one
// segment per step, then the result register; an ACK without a sample skips the estimator
// steps. The back end takes its next event only once the result register has emptied.
// A two-entry command queue lets events be taken while the back end works.
// Configuration writes are taken only while the block is empty.
module sliding_window_sender_rto_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  swsr_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output swsr_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import swsr_pkg::*;

    logic cmd_valid;
    logic cmd_take;
    cmd_t cmd;

    swsr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd)
    );

    swsr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );
endmodule
